@@ sv/dedc_pkg.sv @@
// Shared types, codes and CRC helpers for the DLE escape deframer with CRC check.
package dedc_pkg;

  localparam int BUF_BYTES_DEFAULT = 64;
  localparam int QDEPTH            = 4;

  localparam logic [7:0] CH_SOH = 8'h01;
  localparam logic [7:0] CH_EOT = 8'h04;
  localparam logic [7:0] CH_DLE = 8'h10;

  typedef enum logic [2:0] {
    KIND_DATA    = 3'd0,
    KIND_OK      = 3'd1,
    KIND_BAD     = 3'd2,
    KIND_NOFRAME = 3'd3,
    KIND_OVER    = 3'd4
  } kind_t;

  typedef struct packed {
    logic [7:0] byte_in;
    logic       last_in_packet;
  } in_item_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] data_byte;
    logic [5:0] payload_length;
    logic       last_of_run;
  } out_item_t;

  // All results caused by one input byte, oldest first.
  typedef struct packed {
    logic [1:0] n;
    out_item_t  r0;
    out_item_t  r1;
  } run_t;

  typedef struct packed {
    logic push;
    run_t run;
  } q_wr_t;

  typedef struct packed {
    logic empty;
    run_t run;
  } q_rd_t;

  function automatic logic [15:0] nib_tab(input logic [3:0] i);
    logic [15:0] v;
    case (i)
      4'h0:    v = 16'h0000;
      4'h1:    v = 16'h1021;
      4'h2:    v = 16'h2042;
      4'h3:    v = 16'h3063;
      4'h4:    v = 16'h4084;
      4'h5:    v = 16'h50a5;
      4'h6:    v = 16'h60c6;
      4'h7:    v = 16'h70e7;
      4'h8:    v = 16'h8108;
      4'h9:    v = 16'h9129;
      4'ha:    v = 16'ha14a;
      4'hb:    v = 16'hb16b;
      4'hc:    v = 16'hc18c;
      4'hd:    v = 16'hd1ad;
      4'he:    v = 16'he1ce;
      default: v = 16'hf1ef;
    endcase
    return v;
  endfunction

  // CRC-16 (poly 0x1021), one byte as two nibble steps, high nibble first.
  function automatic logic [15:0] crc_byte(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] v;
    v = nib_tab(c[15:12] ^ b[7:4]) ^ {c[11:0], 4'h0};
    v = nib_tab(v[15:12] ^ b[3:0]) ^ {v[11:0], 4'h0};
    return v;
  endfunction

endpackage

@@ sv/dle_escape_deframer_crc_check.sv @@
// Top level of the SOH/DLE/EOT deframer with CRC-16 frame check.
//
//   channel  direction  handshake              payload
//   in       receive    in_valid / in_ready    in_item  (byte_in, last_in_packet)
//   out      send       out_valid / out_ready  out_item (kind, data_byte,
//                                                       payload_length, last_of_run)
//
// One byte transaction is taken every cycle while the run queue has room; the
// front end updates frame state and the CRC (two nibble table steps) in that cycle.
// Results leave at one per cycle through the output register while out_ready is high,
// so a byte that causes two results takes two out transactions; records pass the queue, then the output register.
// Reset (rst, synchronous) clears frame state, the escape flag, queue and output valid.
// A stall on out fills the four-record queue; in_ready then drops until a record is popped.
module dle_escape_deframer_crc_check import dedc_pkg::*; #(
  parameter int BUF_BYTES = BUF_BYTES_DEFAULT
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_item
);

  q_wr_t q_wr;
  q_rd_t q_rd;
  logic  q_full;
  logic  q_pop;
  logic  in_accept;

  // Accept whenever a record slot is free; bytes with no result take no slot.
  assign in_ready  = !q_full;
  assign in_accept = in_valid && in_ready;

  dedc_front #(
    .BUF_BYTES(BUF_BYTES)
  ) u_front (
    .clk    (clk),
    .rst    (rst),
    .accept (in_accept),
    .item   (in_item),
    .q_wr   (q_wr)
  );

  dedc_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .q_wr (q_wr),
    .pop  (q_pop),
    .q_rd (q_rd),
    .full (q_full)
  );

  dedc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_rd      (q_rd),
    .pop       (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

endmodule

@@ sv/dedc_front.sv @@
// Front end: unstuffs bytes, keeps frame state and CRC, emits one run record per byte that causes a result.
module dedc_front import dedc_pkg::*; #(
  parameter int BUF_BYTES = BUF_BYTES_DEFAULT
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     accept,
  input  in_item_t item,
  output q_wr_t    q_wr
);

  localparam int CNT_W = $clog2(BUF_BYTES + 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(BUF_BYTES);
  localparam logic [CNT_W-1:0] CNT_TWO  = CNT_W'(2);

  logic             escape_pending, escape_pending_next;
  logic [CNT_W-1:0] frame_count, frame_count_next;
  logic [15:0]      running_crc, running_crc_next;
  logic [7:0]       held0, held0_next, held1, held1_next;
  logic             skip_rest, skip_rest_next;
  logic             overflowed, overflowed_next;

  logic      is_soh, is_dle, is_eot, append, first_ok, no_frame;
  out_item_t first, nofr;
  run_t      run;

  always_comb begin
    escape_pending_next = escape_pending;
    frame_count_next    = frame_count;
    running_crc_next    = running_crc;
    held0_next          = held0;
    held1_next          = held1;
    skip_rest_next      = skip_rest;
    overflowed_next     = overflowed;
    first               = '0;
    first.kind          = KIND_DATA;
    first_ok            = 1'b0;
    nofr                = '0;
    nofr.kind           = KIND_NOFRAME;

    is_soh = item.byte_in == CH_SOH;
    is_dle = item.byte_in == CH_DLE;
    is_eot = item.byte_in == CH_EOT;
    append = !skip_rest && (escape_pending || !(is_soh || is_dle || is_eot));

    if (!skip_rest) begin
      if (escape_pending) begin
        escape_pending_next = 1'b0;
      end else if (is_dle) begin
        escape_pending_next = 1'b1;
      end else if (is_soh) begin
        frame_count_next = '0;
        running_crc_next = '0;
        held0_next       = '0;
        held1_next       = '0;
        overflowed_next  = 1'b0;
      end else if (is_eot && frame_count > CNT_TWO) begin
        first_ok       = 1'b1;
        skip_rest_next = 1'b1;
        if (!overflowed && {held1, held0} == running_crc) begin
          first.kind           = KIND_OK;
          first.payload_length = 6'(frame_count - CNT_TWO);
        end else begin
          first.kind = KIND_BAD;
        end
      end
    end

    if (append) begin
      if (frame_count == CNT_FULL) begin
        // Flag only the first dropped byte of the frame.
        if (!overflowed) begin
          overflowed_next = 1'b1;
          first_ok        = 1'b1;
          first.kind      = KIND_OVER;
        end
      end else begin
        if (frame_count >= CNT_TWO) begin
          running_crc_next = crc_byte(running_crc, held0);
          held0_next       = held1;
          held1_next       = item.byte_in;
        end else if (frame_count[0]) begin
          held1_next = item.byte_in;
        end else begin
          held0_next = item.byte_in;
        end
        frame_count_next = frame_count + CNT_W'(1);
        first_ok         = 1'b1;
        first.kind       = KIND_DATA;
        first.data_byte  = item.byte_in;
      end
    end

    no_frame = !skip_rest && item.last_in_packet && !skip_rest_next;

    if (item.last_in_packet) begin
      skip_rest_next   = 1'b0;
      frame_count_next = '0;
      running_crc_next = '0;
      held0_next       = '0;
      held1_next       = '0;
      overflowed_next  = 1'b0;
    end

    run = '0;
    if (first_ok) begin
      run.r0 = first;
      if (no_frame) begin
        run.n              = 2'd2;
        run.r1             = nofr;
        run.r1.last_of_run = 1'b1;
      end else begin
        run.n              = 2'd1;
        run.r0.last_of_run = 1'b1;
      end
    end else if (no_frame) begin
      run.n              = 2'd1;
      run.r0             = nofr;
      run.r0.last_of_run = 1'b1;
    end
  end

  assign q_wr.push = accept && (run.n != 2'd0);
  assign q_wr.run  = run;

  always_ff @(posedge clk) begin
    if (rst) begin
      escape_pending <= 1'b0;
      frame_count    <= '0;
      running_crc    <= '0;
      held0          <= '0;
      held1          <= '0;
      skip_rest      <= 1'b0;
      overflowed     <= 1'b0;
    end else if (accept) begin
      escape_pending <= escape_pending_next;
      frame_count    <= frame_count_next;
      running_crc    <= running_crc_next;
      held0          <= held0_next;
      held1          <= held1_next;
      skip_rest      <= skip_rest_next;
      overflowed     <= overflowed_next;
    end
  end

endmodule

@@ sv/dedc_queue.sv @@
// Short FIFO of run records between the front and back ends.
module dedc_queue import dedc_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  q_wr_t q_wr,
  input  logic  pop,
  output q_rd_t q_rd,
  output logic  full
);

  localparam int QA_W = $clog2(QDEPTH);

  run_t            mem [QDEPTH];
  logic [QA_W-1:0] wr_ptr, rd_ptr;
  logic [QA_W:0]   count;

  assign full       = count == (QA_W+1)'(QDEPTH);
  assign q_rd.empty = count == '0;
  assign q_rd.run   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (q_wr.push) begin
      mem[wr_ptr] <= q_wr.run;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (q_wr.push) begin
        wr_ptr <= wr_ptr + QA_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QA_W'(1);
      end
      case ({q_wr.push, pop})
        2'b10:   count <= count + (QA_W+1)'(1);
        2'b01:   count <= count - (QA_W+1)'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

@@ sv/dedc_back.sv @@
// Back end: expands run records into single results behind an output register.
module dedc_back import dedc_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  q_rd_t     q_rd,
  output logic      pop,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_item
);

  logic      pending;
  out_item_t pend_item;
  logic      load;

  // Output register free when empty or being taken this cycle.
  assign load = !out_valid || out_ready;
  assign pop  = load && !pending && !q_rd.empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      pending   <= 1'b0;
    end else if (load) begin
      if (pending) begin
        out_valid <= 1'b1;
        pending   <= 1'b0;
      end else if (!q_rd.empty) begin
        out_valid <= 1'b1;
        pending   <= q_rd.run.n == 2'd2;
      end else begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      if (pending) begin
        out_item <= pend_item;
      end else if (!q_rd.empty) begin
        out_item  <= q_rd.run.r0;
        pend_item <= q_rd.run.r1;
      end
    end
  end

endmodule

@@ tb/tb_top.sv @@
// Self-checking testbench for the SOH/DLE/EOT deframer with CRC-16 frame check.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import dedc_pkg::*;

  localparam int BUF_BYTES       = BUF_BYTES_DEFAULT;
  localparam int GAP_MAX         = 18;
  localparam int RANDOM_BYTES    = 400;
  localparam int HOLD_OFF_CYCLES = 400;
  // Margin for the queue and output register, and for a two-result run draining.
  localparam int DRAIN_CYCLES    = 8;

  logic      clk       = 1'b0;
  logic      rst       = 1'b1;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_item_t  in_item   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_item;

  dle_escape_deframer_crc_check #(.BUF_BYTES(BUF_BYTES)) dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_item (out_item)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Deframer state as the testbench sees it, updated once per accepted byte.
  // ---------------------------------------------------------------------------
  bit          esc_pending;      // next byte is literal; survives packet ends
  int          frame_len;        // bytes appended to the current frame
  logic [15:0] crc_acc;          // CRC of all appended bytes but the two held
  logic [7:0]  held [2];         // two newest appended bytes, oldest first
  bit          skip_pkt;         // frame verdict given; ignore rest of packet
  bit          buf_overflowed;   // a byte of this frame was dropped

  out_item_t   run_results [$];  // results of the byte being predicted
  out_item_t   due_results [$];  // results still awaited from the block

  int          errors      = 0;
  int          bytes_sent  = 0;
  int          frames_ok   = 0;
  int          frames_bad  = 0;
  int          no_frames   = 0;
  int          overflows   = 0;
  int          data_seen   = 0;

  // Sender and receiver idling controls.
  bit          tx_idle     = 1'b1;
  bit          rx_idle     = 1'b1;
  int          rx_gap      = 0;
  int          rx_hold     = 0;

  logic [7:0]  pkt_bytes [$];    // raw bytes of the packet being built

  // Bitwise CRC-16, poly 0x1021, MSB first; matches the nibble-table form.
  function automatic logic [15:0] crc16_update(input logic [15:0] c, input logic [7:0] d);
    logic [15:0] r;
    r = c ^ {d, 8'h00};
    for (int i = 0; i < 8; i++) r = r[15] ? ((r << 1) ^ 16'h1021) : (r << 1);
    return r;
  endfunction

  function automatic void clear_frame();
    frame_len      = 0;
    crc_acc        = '0;
    held[0]        = '0;
    held[1]        = '0;
    buf_overflowed = 1'b0;
  endfunction

  function automatic void add_result(input kind_t k, input logic [7:0] d,
                                     input logic [5:0] plen);
    out_item_t r;
    r.kind           = k;
    r.data_byte      = d;
    r.payload_length = plen;
    r.last_of_run    = 1'b0;
    run_results.push_back(r);
  endfunction

  // Append one unstuffed byte; the CRC trails the appended bytes by two.
  function automatic void append_frame_byte(input logic [7:0] b);
    if (frame_len >= BUF_BYTES) begin
      // Flag only the first dropped byte of a frame.
      if (!buf_overflowed) begin
        buf_overflowed = 1'b1;
        add_result(KIND_OVER, 8'h00, 6'd0);
      end
      return;
    end
    if (frame_len >= 2) begin
      crc_acc = crc16_update(crc_acc, held[0]);
      held[0] = held[1];
      held[1] = b;
    end else begin
      held[frame_len] = b;
    end
    frame_len++;
    add_result(KIND_DATA, b, 6'd0);
  endfunction

  // Work out every result one accepted byte causes and queue them.
  function automatic void deframe_byte(input in_item_t it);
    out_item_t tail;
    logic [5:0] plen;
    run_results.delete();
    if (!skip_pkt) begin
      if (esc_pending) begin
        esc_pending = 1'b0;
        append_frame_byte(it.byte_in);
      end else if (it.byte_in == CH_SOH) begin
        clear_frame();
      end else if (it.byte_in == CH_DLE) begin
        esc_pending = 1'b1;
      end else if (it.byte_in == CH_EOT) begin
        // Short EOT, with two or fewer bytes held, does nothing.
        if (frame_len > 2) begin
          plen = 6'(frame_len - 2);
          if (!buf_overflowed && {held[1], held[0]} == crc_acc)
            add_result(KIND_OK, 8'h00, plen);
          else
            add_result(KIND_BAD, 8'h00, 6'd0);
          skip_pkt = 1'b1;
        end
      end else begin
        append_frame_byte(it.byte_in);
      end
      if (it.last_in_packet && !skip_pkt) add_result(KIND_NOFRAME, 8'h00, 6'd0);
    end
    // Packet end clears the frame but keeps a pending escape.
    if (it.last_in_packet) begin
      skip_pkt = 1'b0;
      clear_frame();
    end
    if (run_results.size() > 0) begin
      tail = run_results.pop_back();
      tail.last_of_run = 1'b1;
      run_results.push_back(tail);
    end
    foreach (run_results[i]) due_results.push_back(run_results[i]);
  endfunction

  // ---------------------------------------------------------------------------
  // Sender: one byte transaction, with a random gap drawn before it while tx_idle is set.
  // ---------------------------------------------------------------------------
  task automatic push_byte(input logic [7:0] b, input bit last);
    int gap;
    in_item_t it;
    it.byte_in        = b;
    it.last_in_packet = last;
    gap = tx_idle ? $urandom_range(0, GAP_MAX) : 0;
    // Lower valid only when a gap follows, so valid is never dropped and
    // raised in the same step.
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    deframe_byte(it);
    bytes_sent++;
  endtask

  task automatic send_packet();
    foreach (pkt_bytes[i]) push_byte(pkt_bytes[i], i == pkt_bytes.size() - 1);
    pkt_bytes.delete();
  endtask

  // Half the time a random byte, otherwise one of the control codes.
  function automatic logic [7:0] rough_byte();
    case ($urandom_range(0, 5))
      0:       return CH_SOH;
      1:       return CH_DLE;
      2:       return CH_EOT;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Stuff a frame byte: escape control codes, and now and then a plain byte too.
  function automatic void stuff_byte(input logic [7:0] b);
    if (b == CH_SOH || b == CH_DLE || b == CH_EOT || $urandom_range(0, 9) == 0)
      pkt_bytes.push_back(CH_DLE);
    pkt_bytes.push_back(b);
  endfunction

  // Build and send one framed packet: optional junk before SOH, stuffed payload
  // and CRC, EOT (unless left out), then trailing bytes, skipped once EOT gives a verdict.
  task automatic send_frame(input int plen, input bit corrupt, input int prefix,
                            input int trail, input bit no_eot);
    logic [15:0] crc;
    logic [7:0]  b;
    pkt_bytes.delete();
    // Absorb an escape carried over from the previous packet.
    if (esc_pending) pkt_bytes.push_back(8'h55);
    repeat (prefix) pkt_bytes.push_back(8'($urandom_range(8'h20, 8'hff)));
    pkt_bytes.push_back(CH_SOH);
    crc = '0;
    repeat (plen) begin
      b   = rough_byte();
      crc = crc16_update(crc, b);
      stuff_byte(b);
    end
    if (corrupt) crc ^= 16'(1 << $urandom_range(0, 15));
    stuff_byte(crc[7:0]);
    stuff_byte(crc[15:8]);
    if (!no_eot) pkt_bytes.push_back(CH_EOT);
    repeat (trail) pkt_bytes.push_back(rough_byte());
    send_packet();
  endtask

  task automatic send_noise(input int len);
    repeat (len) pkt_bytes.push_back(rough_byte());
    send_packet();
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: after each result transaction draw a wait while rx_idle is set, or
  // hold off for a long stretch when asked.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (rx_hold > 0) begin
      out_ready <= 1'b0;
      rx_hold--;
    end else if (out_ready && out_valid) begin
      rx_gap = rx_idle ? $urandom_range(0, GAP_MAX) : 0;
      out_ready <= (rx_gap == 0);
    end else if (rx_gap > 0) begin
      rx_gap--;
      out_ready <= (rx_gap == 0);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Checker: compare every result transaction with the oldest awaited one.
  // ---------------------------------------------------------------------------
  function automatic void check_field(input string name, input int want, input int got);
    if (want != got) begin
      errors++;
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endfunction

  always @(posedge clk) begin : check_results
    out_item_t want;
    if (!rst && out_valid && out_ready) begin
      case (out_item.kind)
        KIND_DATA:    data_seen++;
        KIND_OK:      frames_ok++;
        KIND_BAD:     frames_bad++;
        KIND_NOFRAME: no_frames++;
        default:      overflows++;
      endcase
      if (due_results.size() == 0) begin
        errors++;
        $display("%0t ns: unexpected result, expected none, actual kind %0d data %0d",
                 $time, out_item.kind, out_item.data_byte);
      end else begin
        want = due_results.pop_front();
        check_field("kind", want.kind, out_item.kind);
        check_field("data_byte", want.data_byte, out_item.data_byte);
        check_field("payload_length", want.payload_length, out_item.payload_length);
        check_field("last_of_run", want.last_of_run, out_item.last_of_run);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Field extremes, each control code and the short cases, byte by byte.
  task automatic test_directed();
    push_byte(8'h00, 1'b0);
    push_byte(8'hff, 1'b1);          // data, then no frame at packet end
    push_byte(CH_EOT, 1'b1);         // EOT on an empty frame
    push_byte(CH_SOH, 1'b0);
    push_byte(8'h41, 1'b0);
    push_byte(8'h42, 1'b0);
    push_byte(CH_EOT, 1'b1);         // two held bytes: still too short
    push_byte(CH_DLE, 1'b1);         // escape carries into the next packet
    push_byte(CH_EOT, 1'b0);         // literal EOT
    push_byte(CH_DLE, 1'b0);
    push_byte(CH_DLE, 1'b1);         // escaped DLE is data
    send_frame(1, 1'b0, 0, 2, 1'b0); // smallest good frame, tail skipped
    send_frame(1, 1'b1, 0, 0, 1'b0); // CRC mismatch with EOT ending the packet
  endtask

  // Largest frame that fits, then frames that run past the buffer.
  task automatic test_buffer_limits();
    send_frame(BUF_BYTES - 2, 1'b0, 0, 1, 1'b0);
    send_frame(BUF_BYTES + 2, 1'b0, 0, 0, 1'b0);
    send_frame(BUF_BYTES + 6, 1'b0, 0, 0, 1'b1);
  endtask

  // Hold the receiver off while the sender keeps offering bytes, so the run
  // queue fills and in_ready drops.
  task automatic test_backpressure();
    tx_idle = 1'b0;
    rx_hold = HOLD_OFF_CYCLES;
    repeat (3) send_frame(8, 1'b0, 0, 1, 1'b0);
    tx_idle = 1'b1;
  endtask

  // Framed packets with random content, some corrupted or without EOT, plus noise and single bytes.
  task automatic test_random();
    int stop_at;
    int plen;
    stop_at = bytes_sent + RANDOM_BYTES;
    while (bytes_sent < stop_at) begin
      // Leave some packets with no idling on either side.
      tx_idle = $urandom_range(0, 3) != 0;
      rx_idle = $urandom_range(0, 3) != 0;
      plen = ($urandom_range(0, 31) == 0) ? $urandom_range(55, 70) : $urandom_range(0, 12);
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5:
          send_frame(plen, $urandom_range(0, 4) == 0, $urandom_range(0, 2),
                     $urandom_range(0, 3), 1'b0);
        6:       send_frame(plen, 1'b0, 0, $urandom_range(0, 2), 1'b1);
        7, 8:    send_noise($urandom_range(1, 8));
        default: push_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      endcase
    end
    tx_idle = 1'b1;
    rx_idle = 1'b1;
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    esc_pending = 1'b0;
    skip_pkt    = 1'b0;
    clear_frame();
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    test_directed();
    test_buffer_limits();
    test_backpressure();
    test_random();

    // Drop valid once the last byte transaction has gone.
    in_valid <= 1'b0;
    while (due_results.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d bytes; saw %0d data results, %0d good frames, %0d CRC failures,",
             bytes_sent, data_seen, frames_ok, frames_bad);
    $display("%0d packets without a frame and %0d buffer overflows, under random stalls.",
             no_frames, overflows);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Guard against a hung handshake.
  initial begin
    #5_000_000;
    $display("Timeout with %0d results still awaited", due_results.size());
    $display("DONE: errors detected");
    $finish;
  end

endmodule
